@@ hw/rtl/stable_load_detector_assert.svh @@
// Assertion macros for the stable load detector.
`ifndef STABLE_LOAD_DETECTOR_ASSERT_SVH
`define STABLE_LOAD_DETECTOR_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SLD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sld check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define SLD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sld check failed");

`endif

@@ hw/rtl/sld_pkg.sv @@
// Package: shared types, codes and helpers of the stable load detector.
package sld_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int MAX_TRACKED_DEF   = 8;

    localparam int ADDR_W   = 64;
    localparam int DATA_W   = 64;
    localparam int SIZE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int BUCKET_W = 3;
    localparam int VERD_W   = 3;
    localparam int OCC_W    = 32;
    localparam int BIN_W    = 48;
    localparam int HIST_DEPTH = 24;
    localparam int HIST_IDX_W = KIND_W + BUCKET_W;

    localparam logic [KIND_W-1:0] KIND_RIP   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STACK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REG   = 2'd2;

    localparam logic [BUCKET_W-1:0] BUCKET_ODD = 3'd7;

    localparam logic [VERD_W-1:0] V_IGNORED  = 3'd0;
    localparam logic [VERD_W-1:0] V_COUNTED  = 3'd1;
    localparam logic [VERD_W-1:0] V_UNSTABLE = 3'd2;
    localparam logic [VERD_W-1:0] V_NEW      = 3'd3;
    localparam logic [VERD_W-1:0] V_REPEAT   = 3'd4;
    localparam logic [VERD_W-1:0] V_BROKE    = 3'd5;
    localparam logic [VERD_W-1:0] V_FULL     = 3'd6;

    // One load request travelling down the cell row.
    typedef struct packed {
        logic                vld;
        logic                done;
        logic [ADDR_W-1:0]   key;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   data;
        logic [KIND_W-1:0]   kind;
        logic [BUCKET_W-1:0] bucket;
        logic [VERD_W-1:0]   verdict;
        logic [OCC_W-1:0]    occ;
        logic [BIN_W-1:0]    bin;
    } t_probe;

    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [SIZE_W-1:0] size);
        logic [BUCKET_W-1:0] b;
        case (size)
            8'd1:    b = 3'd0;
            8'd2:    b = 3'd1;
            8'd4:    b = 3'd2;
            8'd8:    b = 3'd3;
            8'd16:   b = 3'd4;
            8'd32:   b = 3'd5;
            8'd64:   b = 3'd6;
            default: b = BUCKET_ODD;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/sld_front.sv @@
// Front stage: classify, mask data, update histogram, launch request into the row.
module sld_front #(
    parameter int MAX_TRACKED_BYTES = sld_pkg::MAX_TRACKED_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_wdata,
    input  logic                        i_take,
    input  logic                        i_advance,
    input  logic [sld_pkg::ADDR_W-1:0]  i_key,
    input  logic [sld_pkg::ADDR_W-1:0]  i_addr,
    input  logic [sld_pkg::SIZE_W-1:0]  i_size,
    input  logic                        i_rip,
    input  logic                        i_stack,
    input  logic [sld_pkg::DATA_W-1:0]  i_data,
    output sld_pkg::t_probe             o_probe
);

    logic                          r_track;
    logic [sld_pkg::BIN_W-1:0]     r_hist [sld_pkg::HIST_DEPTH];
    sld_pkg::t_probe               r_p;
    sld_pkg::t_probe               n_p;

    logic [sld_pkg::KIND_W-1:0]     w_kind;
    logic [sld_pkg::BUCKET_W-1:0]   w_bucket;
    logic [sld_pkg::HIST_IDX_W-1:0] w_idx;
    logic [sld_pkg::BIN_W-1:0]      w_bin_new;
    logic [sld_pkg::DATA_W-1:0]     w_data;
    logic                           w_tracked;
    logic                           w_hist_we;

    assign w_kind    = i_rip ? sld_pkg::KIND_RIP :
                       (i_stack ? sld_pkg::KIND_STACK : sld_pkg::KIND_REG);
    assign w_bucket  = sld_pkg::bucket_of(i_size);
    assign w_idx     = {w_kind, w_bucket};
    assign w_bin_new = (&r_hist[w_idx]) ? r_hist[w_idx] : r_hist[w_idx] + 1'b1;
    assign w_tracked = (i_size <= sld_pkg::SIZE_W'(MAX_TRACKED_BYTES));
    assign w_hist_we = i_take && r_track;

    always_comb begin
        for (int b = 0; b < sld_pkg::DATA_W / 8; b++) begin
            w_data[b*8 +: 8] = (sld_pkg::SIZE_W'(b) < i_size) ? i_data[b*8 +: 8] : 8'd0;
        end
    end

    always_comb begin
        n_p         = '0;
        n_p.vld     = i_take;
        n_p.key     = i_key;
        n_p.addr    = i_addr;
        n_p.data    = w_data;
        if (!r_track) begin
            n_p.done    = 1'b1;
            n_p.verdict = sld_pkg::V_IGNORED;
        end else begin
            n_p.kind    = w_kind;
            n_p.bucket  = w_bucket;
            n_p.bin     = w_bin_new;
            n_p.done    = !w_tracked;
            n_p.verdict = w_tracked ? sld_pkg::V_IGNORED : sld_pkg::V_COUNTED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= 1'b0;
            r_p.vld <= 1'b0;
            for (int h = 0; h < sld_pkg::HIST_DEPTH; h++) begin
                r_hist[h] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_track <= i_cfg_wdata;
            end
            if (w_hist_we) begin
                r_hist[w_idx] <= w_bin_new;
            end
            if (i_advance) begin
                r_p.vld <= n_p.vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_p.done    <= n_p.done;
            r_p.key     <= n_p.key;
            r_p.addr    <= n_p.addr;
            r_p.data    <= n_p.data;
            r_p.kind    <= n_p.kind;
            r_p.bucket  <= n_p.bucket;
            r_p.verdict <= n_p.verdict;
            r_p.occ     <= n_p.occ;
            r_p.bin     <= n_p.bin;
        end
    end

    assign o_probe = r_p;

endmodule

@@ hw/rtl/sld_cell.sv @@
// Table cell: one entry of the load table, resolves and forwards a request.
module sld_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  sld_pkg::t_probe i_probe,
    output sld_pkg::t_probe o_probe
);

    logic                        r_valid;
    logic [sld_pkg::ADDR_W-1:0]  r_key;
    logic [sld_pkg::ADDR_W-1:0]  r_addr;
    logic [sld_pkg::DATA_W-1:0]  r_value;
    logic                        r_unst;
    logic [sld_pkg::OCC_W-1:0]   r_count;
    sld_pkg::t_probe             r_p;
    sld_pkg::t_probe             n_p;

    logic                        w_live;
    logic                        w_hit;
    logic                        w_alloc;
    logic                        w_same;
    logic [sld_pkg::OCC_W-1:0]   w_count_inc;

    assign w_live      = i_probe.vld && !i_probe.done;
    assign w_hit       = w_live && r_valid && (r_key == i_probe.key);
    assign w_alloc     = w_live && !r_valid;
    assign w_same      = (r_addr == i_probe.addr) && (r_value == i_probe.data);
    assign w_count_inc = (&r_count) ? r_count : r_count + 1'b1;

    always_comb begin
        n_p = i_probe;
        if (w_hit) begin
            n_p.done = 1'b1;
            if (r_unst) begin
                n_p.verdict = sld_pkg::V_UNSTABLE;
            end else if (!w_same) begin
                n_p.verdict = sld_pkg::V_BROKE;
            end else begin
                n_p.verdict = sld_pkg::V_REPEAT;
                n_p.occ     = w_count_inc;
            end
        end else if (w_alloc) begin
            n_p.done    = 1'b1;
            n_p.verdict = sld_pkg::V_NEW;
            n_p.occ     = sld_pkg::OCC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_p.vld <= 1'b0;
        end else if (i_advance) begin
            r_p.vld <= n_p.vld;
            if (w_alloc) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_p.done    <= n_p.done;
            r_p.key     <= n_p.key;
            r_p.addr    <= n_p.addr;
            r_p.data    <= n_p.data;
            r_p.kind    <= n_p.kind;
            r_p.bucket  <= n_p.bucket;
            r_p.verdict <= n_p.verdict;
            r_p.occ     <= n_p.occ;
            r_p.bin     <= n_p.bin;
            if (w_alloc) begin
                r_key   <= i_probe.key;
                r_addr  <= i_probe.addr;
                r_value <= i_probe.data;
                r_unst  <= 1'b0;
                r_count <= sld_pkg::OCC_W'(1);
            end else if (w_hit && !r_unst) begin
                if (w_same) begin
                    r_count <= w_count_inc;
                end else begin
                    r_unst <= 1'b1;
                end
            end
        end
    end

    assign o_probe = r_p;

endmodule

@@ hw/rtl/stable_load_detector.sv @@
// Top level: stable load detector, front stage, row of table cells, output register.
//
//  channel  dir  handshake                        payload, low bits first
//  s_axis   in   i_s_axis_tvalid/o_s_axis_tready  tdata: key addr size data; tuser: rip stack
//  m_axis   out  o_m_axis_tvalid/i_m_axis_tready  tdata: bucket verdict occ bin; tuser: kind
//  cfg      in   i_cfg_we                         i_cfg_wdata: tracking_enabled
//
// One request per cycle unless a stalled output freezes the row; a request passes the front
// register, one cell register per table entry (the cell row), then the output register.
// Reset clears the histogram, entry valid bits and all pipeline valids.
// A stalled output freezes the row only when the last cell holds a request;
// bubbles keep moving, so new requests are taken while a result waits.
module stable_load_detector #(
    parameter int TABLE_ENTRIES     = sld_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_TRACKED_BYTES = sld_pkg::MAX_TRACKED_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_wdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [199:0] i_s_axis_tdata,  // instr_addr, eff_addr, size_bytes, load_data
    input  logic [1:0]   i_s_axis_tuser,  // base_is_rip, base_is_stack
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [87:0]  o_m_axis_tdata,  // size_bucket, verdict, occurrences, bin_count, pad
    output logic [1:0]   o_m_axis_tuser   // load_kind
);

    sld_pkg::t_probe w_p [TABLE_ENTRIES+1];
    sld_pkg::t_probe w_fin;
    sld_pkg::t_probe r_o;
    logic            r_ovld;
    logic            w_advance;
    logic            w_take;
    logic            w_out_load;
    logic            w_o_blank;

    assign w_out_load      = !r_ovld || i_m_axis_tready;
    assign w_advance       = !w_p[TABLE_ENTRIES].vld || w_out_load;
    assign o_s_axis_tready = w_advance;
    assign w_take          = i_s_axis_tvalid && w_advance;

    sld_front #(
        .MAX_TRACKED_BYTES(MAX_TRACKED_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_take     (w_take),
        .i_advance  (w_advance),
        .i_key      (i_s_axis_tdata[63:0]),
        .i_addr     (i_s_axis_tdata[127:64]),
        .i_size     (i_s_axis_tdata[135:128]),
        .i_rip      (i_s_axis_tuser[0]),
        .i_stack    (i_s_axis_tuser[1]),
        .i_data     (i_s_axis_tdata[199:136]),
        .o_probe    (w_p[0])
    );

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        sld_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_advance(w_advance),
            .i_probe  (w_p[g]),
            .o_probe  (w_p[g+1])
        );
    end

    // unresolved at the end of the row: no free entry
    always_comb begin
        w_fin = w_p[TABLE_ENTRIES];
        if (!w_fin.done) begin
            w_fin.verdict = sld_pkg::V_FULL;
            w_fin.occ     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_out_load) begin
            r_ovld <= w_fin.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o <= w_fin;
        end
    end

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tuser  = r_o.kind;
    assign o_m_axis_tdata  = {2'b00, r_o.bin, r_o.occ, r_o.verdict, r_o.bucket};

    assign w_o_blank = (r_o.occ == '0) && (r_o.bin == '0) && (r_o.kind == sld_pkg::KIND_RIP)
                       && (r_o.bucket == '0);

`include "stable_load_detector_assert.svh"

    `SLD_ASSERT_NOW(a_ignored_zero, r_ovld && (r_o.verdict == sld_pkg::V_IGNORED), w_o_blank)
    `SLD_ASSERT_NOW(a_new_count_one, r_ovld && (r_o.verdict == sld_pkg::V_NEW), r_o.occ == 1)
    `SLD_ASSERT_NOW(a_counted_bin, r_ovld && (r_o.verdict != sld_pkg::V_IGNORED), r_o.bin != '0)
    `SLD_ASSERT_NEXT(a_stall_holds, r_ovld && !i_m_axis_tready, r_ovld && $stable(r_o))

endmodule
